FILE: sv/sbffa_pkg.sv
// Shared types and constants for the segment bitmap first-fit allocator.
// Depends on nothing; every other file of the block imports it.
package sbffa_pkg;

    // Area geometry.
    localparam int SEGMENTS  = 32;
    localparam int SEG_PAGES = 1024;

    localparam int PAGE_W = 20;
    localparam int DATA_W = 2 * PAGE_W;

    // Segment positions and run lengths, wide enough for position plus length.
    localparam int POS_W = $clog2(2 * SEGMENTS + 1);

    // Page accumulator: holds SEGMENTS * SEG_PAGES and compares against a page count.
    localparam int ACC_RAW = $clog2(SEGMENTS * SEG_PAGES + 1);
    localparam int ACC_W   = ((ACC_RAW > PAGE_W) ? ACC_RAW : PAGE_W) + 1;

    typedef logic [SEGMENTS-1:0] t_map;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [ACC_W-1:0]    t_acc;
    typedef logic [PAGE_W-1:0]   t_page;

    // Request kinds.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 1'b1;

    localparam t_page BASE_RESET = 20'd524288;
    localparam t_page MAX_RESET  = 20'd32768;

endpackage

FILE: sv/sbffa_run_mask.sv
// Run mask generator: marks the segments from a start position over a length.
// Depends on sbffa_pkg for the map and position types.
module sbffa_run_mask (
    input  sbffa_pkg::t_pos i_pos,
    input  sbffa_pkg::t_pos i_len,
    output sbffa_pkg::t_map o_mask
);
    import sbffa_pkg::*;

    t_pos w_end;

    // The end never overflows: both operands are at most SEGMENTS.
    assign w_end = i_pos + i_len;

    always_comb begin
        for (int i = 0; i < SEGMENTS; i++) begin
            o_mask[i] = (t_pos'(i) >= i_pos) && (t_pos'(i) < w_end);
        end
    end

endmodule

FILE: sv/segment_bitmap_first_fit_allocator_core.sv
// Top level of the segment bitmap first-fit allocator: sequencer, state and ports.
// Depends on sbffa_pkg and sbffa_run_mask.
//
//  Channel   Direction  Handshake            Payload
//  s (req)   in         i_s_tvalid/o_s_tready tuser: opcode; tdata: size_pages, release_page
//  m (resp)  out        o_m_tvalid/i_m_tready tuser: ok; tdata: start_page, pages_in_use
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One shared adder steps one segment per cycle, first to size a request's run,
// then to scan or locate its position. Oversized allocations go from idle
// straight to the apply state. The request side is ready only when
// the sequencer is idle; a result waits in the output register while a new
// request is taken. Reset empties the bitmap and the page count.
module segment_bitmap_first_fit_allocator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Requests.
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic                      i_s_tuser,   // [0] opcode
    input  logic [sbffa_pkg::DATA_W-1:0] i_s_tdata, // [19:0] size_pages, [39:20] release_page
    // Responses.
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic                      o_m_tuser,   // [0] ok
    output logic [sbffa_pkg::DATA_W-1:0] o_m_tdata, // [19:0] start_page, [39:20] pages_in_use
    // Configuration writes.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sbffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbffa_pkg::PAGE_W-1:0]    i_cfg_data
);
    import sbffa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SIZE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_LOCATE = 5'b01000,
        ST_APPLY  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_page r_base, r_max;
    t_map  r_map, n_map;
    t_page r_total, n_total;

    logic  r_op;
    t_page r_size, r_addr;
    t_pos  r_n, n_n;
    t_pos  r_pos, n_pos;
    t_acc  r_acc, n_acc;
    logic  r_found, n_found;

    logic  r_out_valid, n_out_valid;
    logic  r_out_ok, n_out_ok;
    t_page r_out_start, n_out_start;
    t_page r_out_total, n_out_total;

    t_map  w_mask;
    t_acc  w_acc_step;
    t_page w_dist;
    logic  w_out_free;
    logic  w_accept;
    logic [PAGE_W:0] w_sum;

    sbffa_run_mask u_mask (
        .i_pos  (r_pos),
        .i_len  (r_n),
        .o_mask (w_mask)
    );

    // The one shared adder: steps the page accumulator by a segment.
    assign w_acc_step = r_acc + t_acc'(SEG_PAGES);
    assign w_dist     = r_addr - r_base;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_sum      = {1'b0, r_total} + {1'b0, r_size};

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_ok;
    assign o_m_tdata   = {r_out_total, r_out_start};

    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_total     = r_total;
        n_n         = r_n;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ok    = r_out_ok;
        n_out_start = r_out_start;
        n_out_total = r_out_total;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_n     = t_pos'(1);
                    n_acc   = t_acc'(SEG_PAGES);
                    n_pos   = '0;
                    n_found = 1'b0;
                    if (i_s_tuser == OP_ALLOC && i_s_tdata[PAGE_W-1:0] > r_max) begin
                        n_state = ST_APPLY;
                    end else begin
                        n_state = ST_SIZE;
                    end
                end
            end
            ST_SIZE: begin
                // Round the size up to whole segments, one segment per cycle.
                if (r_acc >= t_acc'(r_size) || r_n == t_pos'(SEGMENTS)) begin
                    n_acc = '0;
                    if (r_op == OP_RELEASE) begin
                        n_state = ST_LOCATE;
                    end else if (r_acc >= t_acc'(r_size)) begin
                        n_state = ST_SCAN;
                    end else begin
                        // More segments than the area holds: the allocation fails.
                        n_state = ST_APPLY;
                    end
                end else begin
                    n_n   = r_n + t_pos'(1);
                    n_acc = w_acc_step;
                end
            end
            ST_SCAN: begin
                if (r_pos + r_n > t_pos'(SEGMENTS)) begin
                    n_state = ST_APPLY;
                end else if ((w_mask & r_map) == '0) begin
                    n_found = 1'b1;
                    n_state = ST_APPLY;
                end else begin
                    n_pos = r_pos + t_pos'(1);
                    n_acc = w_acc_step;
                end
            end
            ST_LOCATE: begin
                // Find the first segment that starts at or above the release page.
                if (r_addr <= r_base || r_acc >= t_acc'(w_dist)
                        || r_pos == t_pos'(SEGMENTS)) begin
                    n_state = ST_APPLY;
                end else begin
                    n_pos = r_pos + t_pos'(1);
                    n_acc = w_acc_step;
                end
            end
            ST_APPLY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_start = '0;
                    if (r_op == OP_RELEASE) begin
                        n_map    = r_map & ~w_mask;
                        n_total  = (r_size > r_total) ? '0 : r_total - r_size;
                        n_out_ok = 1'b1;
                    end else begin
                        n_out_ok = r_found;
                        if (r_found) begin
                            n_map       = r_map | w_mask;
                            n_total     = w_sum[PAGE_W] ? '1 : w_sum[PAGE_W-1:0];
                            n_out_start = r_base + r_acc[PAGE_W-1:0];
                        end
                    end
                    n_out_total = n_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_max       <= MAX_RESET;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_REGION_BASE: r_base <= i_cfg_data;
                    REG_MAX_REQUEST: r_max  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_size <= i_s_tdata[PAGE_W-1:0];
            r_addr <= i_s_tdata[DATA_W-1:PAGE_W];
        end
        r_n         <= n_n;
        r_pos       <= n_pos;
        r_acc       <= n_acc;
        r_found     <= n_found;
        r_out_ok    <= n_out_ok;
        r_out_start <= n_out_start;
        r_out_total <= n_out_total;
    end

    // A request locks the sequencer until its result is built.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("request side ready right after a request was taken");

    // A run marked in use was entirely free before.
    a_alloc_run_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY && w_out_free && r_op == OP_ALLOC && r_found)
            |-> ((w_mask & r_map) == '0) && (w_mask != '0))
        else $error("allocated run overlaps segments in use");

    // A failed allocation reports start page zero.
    a_fail_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[PAGE_W-1:0] == '0))
        else $error("failed request carries a nonzero start page");

    // The run length stays within one to SEGMENTS while the run is scanned or located.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_LOCATE)
            |-> (r_n >= t_pos'(1) && r_n <= t_pos'(SEGMENTS)))
        else $error("run length out of range");

endmodule

FILE: tb/sbffa_grant_checker.sv
// Checker for the segment bitmap first-fit allocator: watches the request, response and
// configuration channels, predicts every response and compares it. Depends on sbffa_pkg.
module sbffa_grant_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic                           i_s_tuser,
    input  logic [sbffa_pkg::DATA_W-1:0]    i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic                           i_m_tuser,
    input  logic [sbffa_pkg::DATA_W-1:0]    i_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [sbffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbffa_pkg::PAGE_W-1:0]    i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    import sbffa_pkg::*;

    typedef struct packed {
        logic  ok;
        t_page start_page;
        t_page pages_in_use;
    } t_grant;

    // With 64 segments the shift wraps to zero and the subtraction gives all ones.
    localparam logic [63:0] AREA_MASK = (64'd1 << SEGMENTS) - 64'd1;

    t_grant      grant_q[$];
    logic [63:0] seg_busy;
    t_page       used_pages;
    t_page       base_page;
    t_page       max_pages;
    t_grant      want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // n contiguous segments from position pos, clipped to the area.
    function automatic logic [63:0] seg_run(input longint unsigned n,
                                            input longint unsigned pos);
        logic [63:0] ones;
        if (pos >= 64)
            return '0;
        ones = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        return (ones << pos) & AREA_MASK;
    endfunction

    task automatic note_mismatch(input string what, input logic [PAGE_W-1:0] got,
                                 input logic [PAGE_W-1:0] exp_val);
        o_mismatches++;
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    task automatic grant_or_release(input logic op, input t_page size, input t_page addr);
        longint unsigned n;
        longint unsigned pos;
        logic [63:0]     run;
        logic [63:0]     sum;
        logic            found;
        t_grant          g;
        n = (64'(size) + 64'(SEG_PAGES) - 64'd1) / 64'(SEG_PAGES);
        if (n == 0)
            n = 1;
        g = '0;
        g.ok = 1'b1;
        if (op == OP_ALLOC) begin
            g.ok  = 1'b0;
            found = 1'b0;
            pos   = 0;
            if (size <= max_pages && n <= SEGMENTS) begin
                while (!found && pos + n <= SEGMENTS) begin
                    if ((seg_run(n, pos) & seg_busy) == 0)
                        found = 1'b1;
                    else
                        pos++;
                end
            end
            if (found) begin
                run = seg_run(n, pos);
                seg_busy = seg_busy | run;
                sum = 64'(used_pages) + 64'(size);
                used_pages = (sum > 64'hFFFFF) ? '1 : sum[PAGE_W-1:0];
                sum = 64'(base_page) + pos * 64'(SEG_PAGES);
                g.start_page = sum[PAGE_W-1:0];
                g.ok = 1'b1;
            end
        end else begin
            pos = 0;
            // The run starts at the first segment boundary at or above the address.
            if (addr > base_page)
                pos = (64'(addr - base_page) + 64'(SEG_PAGES) - 64'd1) / 64'(SEG_PAGES);
            run = seg_run(n, pos);
            seg_busy = seg_busy & ~run;
            used_pages = (size > used_pages) ? '0 : used_pages - size;
        end
        g.pages_in_use = used_pages;
        grant_q.push_back(g);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grant_q.delete();
            seg_busy   = '0;
            used_pages = '0;
            base_page  = BASE_RESET;
            max_pages  = MAX_RESET;
        end else begin
            // A response always belongs to an earlier request, so it is checked first.
            if (i_m_tvalid && i_m_tready) begin
                if (grant_q.size() == 0) begin
                    note_mismatch("response with nothing outstanding",
                                  i_m_tdata[PAGE_W-1:0], '0);
                end else begin
                    want = grant_q.pop_front();
                    if (i_m_tuser !== want.ok)
                        note_mismatch("ok", t_page'(i_m_tuser), t_page'(want.ok));
                    if (i_m_tdata[PAGE_W-1:0] !== want.start_page)
                        note_mismatch("start_page", i_m_tdata[PAGE_W-1:0], want.start_page);
                    if (i_m_tdata[DATA_W-1:PAGE_W] !== want.pages_in_use)
                        note_mismatch("pages_in_use", i_m_tdata[DATA_W-1:PAGE_W],
                                      want.pages_in_use);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_REGION_BASE: base_page = i_cfg_data;
                    REG_MAX_REQUEST: max_pages = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                grant_or_release(i_s_tuser, i_s_tdata[PAGE_W-1:0], i_s_tdata[DATA_W-1:PAGE_W]);
        end
        o_pending = grant_q.size();
    end

endmodule

FILE: tb/segment_bitmap_first_fit_allocator_core_tb.sv
// Testbench top for the segment bitmap first-fit allocator: clock, reset, requests,
// configuration writes and verdict. Depends on sbffa_pkg, the core and sbffa_grant_checker.
module segment_bitmap_first_fit_allocator_core_tb;
    import sbffa_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int DRAIN_CYCLES = 2 * SEGMENTS + 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 60;
    localparam int CLIMB_LAPS   = 34;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic                 i_s_tuser   = 1'b0;
    logic [DATA_W-1:0]    i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic                 o_m_tuser;
    logic [DATA_W-1:0]    o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PAGE_W-1:0]    i_cfg_data  = '0;

    int    mismatch_count;
    int    pending_grants;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    logic  hold_request   = 1'b0;
    logic  hold_on        = 1'b0;
    t_page area_base      = BASE_RESET;

    segment_bitmap_first_fit_allocator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    sbffa_grant_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tuser   (o_m_tuser),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mismatches(mismatch_count),
        .o_pending   (pending_grants)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk)
        i_m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);

    // One long stall of the response side while requests keep coming.
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
            default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
        endcase
    endtask

    task automatic issue_request(input logic op, input t_page size, input t_page addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {addr, size};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_grants != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input t_page base, input t_page max_req);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_REGION_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_MAX_REQUEST;
        i_cfg_data  <= max_req;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        area_base = base;
    endtask

    // Mostly allocations and segment-aligned releases of a few segments, some noise.
    task automatic random_request();
        int    pick;
        int    n;
        int    k;
        t_page size;
        t_page addr;
        pick = $urandom_range(99);
        n    = $urandom_range(1, 6);
        size = t_page'((n - 1) * SEG_PAGES) + t_page'($urandom_range(1, SEG_PAGES));
        if ($urandom_range(9) == 0)
            size = '0;
        k    = $urandom_range(0, SEGMENTS - 1);
        addr = area_base + t_page'(k * SEG_PAGES);
        if ($urandom_range(3) == 0)
            addr = addr - t_page'($urandom_range(0, SEG_PAGES - 1));
        if (pick < 45)
            issue_request(OP_ALLOC, size, t_page'($urandom));
        else if (pick < 85)
            issue_request(OP_RELEASE, size, addr);
        else
            issue_request(1'($urandom_range(1)), t_page'($urandom), t_page'($urandom));
    endtask

    // Fill the whole area, then free it one segment at a time with zero-size releases,
    // which keeps the page count; repeated, this drives the count into saturation.
    task automatic climb_page_count();
        int    order[SEGMENTS];
        int    j;
        int    tmp;
        t_page addr;
        for (int lap = 0; lap < CLIMB_LAPS; lap++) begin
            set_idle(lap % 4);
            issue_request(OP_ALLOC, t_page'($urandom_range((SEGMENTS - 1) * SEG_PAGES + 1,
                                                           SEGMENTS * SEG_PAGES)),
                          t_page'($urandom));
            for (int i = 0; i < SEGMENTS; i++)
                order[i] = i;
            for (int i = SEGMENTS - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < SEGMENTS; i++) begin
                addr = area_base + t_page'(order[i] * SEG_PAGES);
                if (order[i] != 0)
                    addr = addr - t_page'($urandom_range(0, SEG_PAGES - 1));
                issue_request(OP_RELEASE, '0, addr);
            end
        end
        issue_request(OP_RELEASE, '1, area_base);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests against the reset configuration.
        set_idle(0);
        issue_request(OP_ALLOC, 20'd0, 20'd0);
        issue_request(OP_ALLOC, 20'd1, 20'd0);
        issue_request(OP_ALLOC, 20'd1024, 20'd0);
        issue_request(OP_ALLOC, 20'd1025, 20'd0);
        issue_request(OP_ALLOC, 20'd32768, 20'd0);
        issue_request(OP_ALLOC, 20'd32769, 20'd0);
        issue_request(OP_ALLOC, 20'hFFFFF, 20'hFFFFF);
        issue_request(OP_RELEASE, 20'd0, area_base + t_page'(2 * SEG_PAGES));
        issue_request(OP_ALLOC, 20'd700, 20'd0);
        issue_request(OP_RELEASE, 20'd1, 20'd0);
        issue_request(OP_RELEASE, 20'd2048, 20'hFFFFF);
        issue_request(OP_RELEASE, 20'hFFFFF, area_base + 20'd1);
        issue_request(OP_ALLOC, 20'd32768, 20'd0);
        issue_request(OP_ALLOC, 20'd0, 20'd0);
        issue_request(OP_RELEASE, 20'd32768, area_base);

        climb_page_count();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: write_config(20'd0, 20'hFFFFF);
                    2: write_config(20'hFFFFF, 20'd0);
                    3: write_config(20'hFC000, 20'd16384);
                    4: write_config(t_page'($urandom), t_page'($urandom_range(0, 40000)));
                    default: write_config(20'd1, 20'd5000);
                endcase
            end
            set_idle(ph % 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == 5)
                    hold_request <= 1'b1;
                if (ph == 4 && i == 30)
                    wait_drained();
                random_request();
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/sbffa_pkg.sv
sv/sbffa_run_mask.sv
sv/segment_bitmap_first_fit_allocator_core.sv
tb/sbffa_grant_checker.sv
tb/segment_bitmap_first_fit_allocator_core_tb.sv
